FILE: design/lsbpk_pkg.sv
package lsbpk_pkg;

  localparam int OpW     = 4;
  localparam int DataW   = 32;
  localparam int CountW  = 6;
  localparam int StatusW = 2;
  localparam int CursorW = 24;
  localparam int LengthW = 21;

  localparam logic [CountW-1:0] MaxFieldBits = 6'd32;

  typedef enum logic [OpW-1:0] {
    OP_WRITE_BITS  = 4'd0,
    OP_READ_BITS   = 4'd1,
    OP_WRITE_BYTE  = 4'd2,
    OP_READ_BYTE   = 4'd3,
    OP_ALIGN_WRITE = 4'd4,
    OP_ALIGN_READ  = 4'd5,
    OP_RESET_WRITE = 4'd6,
    OP_RESET_READ  = 4'd7,
    OP_CLEAR       = 4'd8
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 2'd0,
    ST_READ_OVER  = 2'd1,
    ST_WRITE_OVER = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WMERGE,
    S_RGATHER,
    S_DONE
  } state_e;

  typedef struct packed {
    logic re;
    logic we;
    logic merge;
    logic fresh;
  } lsbpk_mem_ctrl_t;

  function automatic logic [CursorW-1:0] align_up(input logic [CursorW-1:0] c);
    logic [CursorW-1:0] s;
    s = c + CursorW'(7);
    return {s[CursorW-1:3], 3'b000};
  endfunction

endpackage

FILE: design/lsbpk_store.sv
module lsbpk_store #(
  parameter int Depth = 1024,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                      clk_i,
  input  lsbpk_pkg::lsbpk_mem_ctrl_t ctrl_i,
  input  logic [AddrW-1:0]          raddr_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [7:0]                wbits_i,
  output logic [7:0]                rdata_o
);
  import lsbpk_pkg::*;

  logic [7:0] mem [Depth];
  logic [7:0] rd_q;
  logic [7:0] wdata;

  // A merge ORs new ones into the byte read in the previous cycle, or into zero
  // when the byte lies beyond the stored data.
  always_comb begin
    if (ctrl_i.merge) begin
      wdata = (ctrl_i.fresh ? 8'h00 : rd_q) | wbits_i;
    end else begin
      wdata = wbits_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem[waddr_i] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.re) begin
      rd_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rd_q;

endmodule

FILE: design/lsb_first_bit_packing_buffer.sv
// Bit-granular packing buffer over a byte store, least significant bit first.
// The slave channel takes one command word: tuser carries the operation and
// tdata carries the value and the bit count. The master channel returns one
// result word per command: tuser carries the status, tdata the read value,
// both cursors and the stored byte count.
// One command is worked on at a time. A command without store access and
// a byte write go from the execute state straight to the done state; a bit
// write, bit read or byte read also takes one merge or gather step per stored
// byte touched (up to 5 bytes for a 32-bit field at an odd offset). The loop
// over bytes is set by the single byte memory: each byte is read and is
// merged or gathered in the cycle after, while the following byte is read.
// The done state loads the result once the output register is free.
// Reset zeroes both cursors and the stored length; store contents are left
// as they are and only bytes below the stored length are ever read back.
// A stalled receiver holds the result; the block still accepts one more
// command and finishes it, then waits until the output register is free.
module lsb_first_bit_packing_buffer #(
  parameter int BUFFER_BYTES = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [39:0]  s_axis_tdata_i,   // data_value [31:0], bit_count [37:32]
  input  logic [3:0]   s_axis_tuser_i,   // operation [3:0]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // read_value [31:0], write_bits_used [55:32], read_bits_used [79:56],
  // stored_byte_count [100:80]
  output logic [103:0] m_axis_tdata_o,
  output logic [1:0]   m_axis_tuser_o    // status [1:0]
);
  import lsbpk_pkg::*;

  localparam int AddrW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam logic [CursorW:0] CapBits = (CursorW + 1)'(BUFFER_BYTES * 8);

  state_e               state_q, state_d;
  op_e                  op_q;
  logic [DataW-1:0]     data_q;
  logic [CountW-1:0]    cnt_q;
  logic [CountW-1:0]    cnt_in;
  logic [CursorW-1:0]   wc_q, wc_d, rc_q, rc_d;
  logic [LengthW-1:0]   sl_q, sl_d;
  logic [LengthW-1:0]   addr_q, addr_d;
  logic [2:0]           off_q, off_d;
  logic [CountW-1:0]    rem_q, rem_d, pos_q, pos_d;
  logic [DataW-1:0]     sh_q, sh_d, acc_q, acc_d;
  status_e              status_q, status_d;

  logic                 m_valid_q, m_valid_d;
  logic                 out_load;
  logic [DataW-1:0]     out_value_q;
  status_e              out_status_q;
  logic [CursorW-1:0]   out_wbu_q, out_rbu_q;
  logic [LengthW-1:0]   out_sbc_q;

  lsbpk_mem_ctrl_t      mem_ctrl;
  logic [LengthW-1:0]   raddr, waddr;
  logic [7:0]           wbits, rdata;

  logic                 in_fire;
  logic [CursorW-1:0]   wc_al, rc_al, sl_bits;
  logic [3:0]           room, take;
  logic [8:0]           mask_ext;
  logic [7:0]           low_mask, gbits;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cnt_in = (s_axis_tdata_i[37:32] > MaxFieldBits) ? MaxFieldBits
                                                         : s_axis_tdata_i[37:32];

  assign wc_al    = align_up(wc_q);
  assign rc_al    = align_up(rc_q);
  assign sl_bits  = {sl_q, 3'b000};
  assign room     = 4'd8 - {1'b0, off_q};
  assign take     = ({2'b00, room} > rem_q) ? rem_q[3:0] : room;
  assign mask_ext = (9'd1 << take) - 9'd1;
  assign low_mask = mask_ext[7:0];
  assign gbits    = (rdata >> off_q) & low_mask;

  always_comb begin
    state_d  = state_q;
    wc_d     = wc_q;
    rc_d     = rc_q;
    sl_d     = sl_q;
    addr_d   = addr_q;
    off_d    = off_q;
    rem_d    = rem_q;
    pos_d    = pos_q;
    sh_d     = sh_q;
    acc_d    = acc_q;
    status_d = status_q;
    mem_ctrl = '0;
    raddr    = addr_q + LengthW'(1);
    waddr    = addr_q;
    wbits    = 8'h00;
    out_load = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d  = S_DONE;
        acc_d    = '0;
        status_d = ST_OK;
        off_d    = 3'd0;
        pos_d    = '0;
        case (op_q)
          OP_WRITE_BITS: begin
            if ({1'b0, wc_q} + (CursorW + 1)'(cnt_q) > CapBits) begin
              status_d = ST_WRITE_OVER;
            end else if (cnt_q != '0) begin
              addr_d      = wc_q[CursorW-1:3];
              off_d       = wc_q[2:0];
              rem_d       = cnt_q;
              sh_d        = data_q;
              raddr       = wc_q[CursorW-1:3];
              mem_ctrl.re = 1'b1;
              wc_d        = wc_q + CursorW'(cnt_q);
              state_d     = S_WMERGE;
            end
          end
          OP_READ_BITS: begin
            if ({1'b0, rc_q} + (CursorW + 1)'(cnt_q) > {1'b0, sl_bits}) begin
              rc_d     = sl_bits;
              status_d = ST_READ_OVER;
            end else if (cnt_q != '0) begin
              addr_d      = rc_q[CursorW-1:3];
              off_d       = rc_q[2:0];
              rem_d       = cnt_q;
              raddr       = rc_q[CursorW-1:3];
              mem_ctrl.re = 1'b1;
              rc_d        = rc_q + CursorW'(cnt_q);
              state_d     = S_RGATHER;
            end
          end
          OP_WRITE_BYTE: begin
            wc_d = wc_al;
            if ({1'b0, wc_al} + (CursorW + 1)'(8) > CapBits) begin
              status_d = ST_WRITE_OVER;
            end else begin
              waddr       = wc_al[CursorW-1:3];
              wbits       = data_q[7:0];
              mem_ctrl.we = 1'b1;
              if (wc_al[CursorW-1:3] >= sl_q) begin
                sl_d = wc_al[CursorW-1:3] + LengthW'(1);
              end
              wc_d = wc_al + CursorW'(8);
            end
          end
          OP_READ_BYTE: begin
            if (rc_al[CursorW-1:3] >= sl_q) begin
              rc_d     = sl_bits;
              status_d = ST_READ_OVER;
            end else begin
              addr_d      = rc_al[CursorW-1:3];
              rem_d       = CountW'(8);
              raddr       = rc_al[CursorW-1:3];
              mem_ctrl.re = 1'b1;
              rc_d        = rc_al + CursorW'(8);
              state_d     = S_RGATHER;
            end
          end
          OP_ALIGN_WRITE: wc_d = wc_al;
          OP_ALIGN_READ:  rc_d = rc_al;
          OP_RESET_WRITE: wc_d = '0;
          OP_RESET_READ:  rc_d = '0;
          OP_CLEAR: begin
            wc_d = '0;
            rc_d = '0;
            sl_d = '0;
          end
          default: ;
        endcase
      end
      S_WMERGE: begin
        mem_ctrl.we    = 1'b1;
        mem_ctrl.merge = 1'b1;
        mem_ctrl.fresh = (addr_q >= sl_q);
        wbits          = (sh_q[7:0] & low_mask) << off_q;
        if (addr_q >= sl_q) begin
          sl_d = addr_q + LengthW'(1);
        end
        sh_d   = sh_q >> take;
        rem_d  = rem_q - CountW'(take);
        off_d  = 3'd0;
        addr_d = addr_q + LengthW'(1);
        if (rem_q == CountW'(take)) begin
          state_d = S_DONE;
        end else begin
          mem_ctrl.re = 1'b1;
        end
      end
      S_RGATHER: begin
        acc_d  = acc_q | (DataW'(gbits) << pos_q);
        pos_d  = pos_q + CountW'(take);
        rem_d  = rem_q - CountW'(take);
        off_d  = 3'd0;
        addr_d = addr_q + LengthW'(1);
        if (rem_q == CountW'(take)) begin
          state_d = S_DONE;
        end else begin
          mem_ctrl.re = 1'b1;
        end
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign m_valid_d = out_load || (m_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wc_q      <= '0;
      rc_q      <= '0;
      sl_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wc_q      <= wc_d;
      rc_q      <= rc_d;
      sl_q      <= sl_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= op_e'(s_axis_tuser_i);
      data_q <= s_axis_tdata_i[31:0];
      cnt_q  <= cnt_in;
    end
    addr_q   <= addr_d;
    off_q    <= off_d;
    rem_q    <= rem_d;
    pos_q    <= pos_d;
    sh_q     <= sh_d;
    acc_q    <= acc_d;
    status_q <= status_d;
    if (out_load) begin
      out_value_q  <= acc_q;
      out_status_q <= status_q;
      out_wbu_q    <= wc_q;
      out_rbu_q    <= rc_q;
      out_sbc_q    <= sl_q;
    end
  end

  lsbpk_store #(
    .Depth (BUFFER_BYTES),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .ctrl_i  (mem_ctrl),
    .raddr_i (raddr[AddrW-1:0]),
    .waddr_i (waddr[AddrW-1:0]),
    .wbits_i (wbits),
    .rdata_o (rdata)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_sbc_q, out_rbu_q, out_wbu_q, out_value_q};
  assign m_axis_tuser_o  = out_status_q;

  a_wc_in_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, wc_q} <= CapBits)
    else $error("write cursor beyond capacity");

  a_rc_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rc_q <= sl_bits)
    else $error("read cursor beyond stored data");

  a_idle_no_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !mem_ctrl.re && !mem_ctrl.we)
    else $error("store accessed while idle");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctrl.we |-> state_q == S_EXEC || state_q == S_WMERGE)
    else $error("store written outside a write step");

  a_read_over_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && status_q == ST_READ_OVER |=> out_rbu_q == {out_sbc_q, 3'b000})
    else $error("failed read left cursor away from the end of data");

endmodule
